// ----- design/runq_latency_event_tracker_defines.svh -----
// assertion macros shared by the run-queue latency tracker
`ifndef RUNQ_LATENCY_EVENT_TRACKER_DEFINES_SVH
`define RUNQ_LATENCY_EVENT_TRACKER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define RLET_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rlet assertion failed");

// next-cycle implication, disabled during reset
`define RLET_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rlet assertion failed");

`endif

// ----- design/rlet_pkg.sv -----
// types, constants and helpers of the run-queue latency tracker
package rlet_pkg;

   localparam int DEF_PID_SLOTS       = 65536;
   localparam int DEF_OVERFLOW_BUCKET = 23;
   localparam int NS_PER_US           = 1000;
   localparam int THR_W               = 74;
   localparam int MIN_LAT_W           = 40;
   localparam int CSR_ADDR_W          = 4;
   localparam int CSR_DATA_W          = 64;

   localparam logic [MIN_LAT_W-1:0] MIN_LAT_RESET = 40'd100000;

   localparam logic [1:0] CMD_WAKEUP = 2'd0;
   localparam logic [1:0] CMD_SWITCH = 2'd1;
   localparam logic [1:0] CMD_EXIT   = 2'd2;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [62:0] now_ns;
      logic [15:0] task_pid;
      logic        woken_active;
      logic        preempt;
      logic [15:0] outgoing_pid;
      logic        prev_running;
      logic        prev_kthread;
      logic [63:0] prev_cgroup;
      logic [63:0] next_cgroup;
      logic        next_tracked;
   } req_type;

   typedef struct packed {
      logic        recorded;
      logic [63:0] victim_cgroup;
      logic [4:0]  bucket;
      logic [63:0] culprit_cgroup;
      logic [62:0] latency_ns;
   } rsp_type;

   typedef struct packed {
      logic        valid;
      logic [62:0] stamp;
   } stamp_entry_type;

   // latency in ns at which a given log2-microsecond bucket starts
   function automatic logic [THR_W-1:0] bucket_threshold(input int b);
      logic [THR_W-1:0] base;
      base = THR_W'(NS_PER_US);
      return base << b;
   endfunction

endpackage

// ----- design/runq_latency_event_tracker.sv -----
// top level of the run-queue latency tracker
//
// Items on req_* carry one scheduler event (wakeup, context switch, exit).
// Every accepted item yields exactly one item on rsp_*; recorded is set when
// a switch brings in a tracked task that waited at least min_latency_ns, and
// all other result fields are zero otherwise.
// Pending stamps live in a single-port-write, registered-read memory of
// PID_SLOTS entries. A wakeup may set and an exit clears the task's stamp,
// an unknown event touches none, and each then loads its result; a switch
// may write the prev stamp, reads the next stamp, checks the read data and
// clears a hit, then loads the result. One item is in flight at a time and
// req_ready returns with the edge that loads the result.
// The result sits in an output register: a new item is accepted while a
// finished result waits, and a stalled receiver holds the block only at the
// point where the next result would be loaded.
// After reset the memory is swept to empty, one entry per cycle, over all
// PID_SLOTS entries; req_ready stays low during the sweep while the APB port
// is served as usual. min_latency_ns sits at byte address 0 and resets to
// 100000.
module runq_latency_event_tracker #(
   parameter int PID_SLOTS       = rlet_pkg::DEF_PID_SLOTS,
   parameter int OVERFLOW_BUCKET = rlet_pkg::DEF_OVERFLOW_BUCKET
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  rlet_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output rlet_pkg::rsp_type               rsp_data,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [rlet_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [rlet_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [rlet_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready
);

`include "runq_latency_event_tracker_defines.svh"

   localparam int ADDR_W = $clog2(PID_SLOTS);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_READ,
      ST_CHECK,
      ST_EMIT
   } state_type;

   state_type                         state_ff, state_in;
   logic [ADDR_W-1:0]                 clr_cnt_ff, clr_cnt_in;
   rlet_pkg::req_type                 item_ff, item_in;
   logic                              rec_ff, rec_in;
   logic [62:0]                       lat_ff, lat_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   rlet_pkg::rsp_type                 rsp_data_ff, rsp_data_in;
   logic [rlet_pkg::MIN_LAT_W-1:0]    min_lat_ff, min_lat_in;

   logic                              mem_wr_en;
   logic [ADDR_W-1:0]                 mem_wr_addr;
   rlet_pkg::stamp_entry_type         mem_wr_data;
   logic                              mem_rd_en;
   rlet_pkg::stamp_entry_type         mem_rd_data;

   logic [ADDR_W-1:0]                 pid_addr;
   logic [ADDR_W-1:0]                 prev_addr;
   logic                              pid_ok;
   logic                              prev_ok;
   logic                              hit;
   logic [63:0]                       diff;
   logic                              time_ok;
   logic                              above_floor;
   logic [4:0]                        bucket;
   logic                              csr_wr;

   assign pid_addr  = ADDR_W'(32'(item_ff.task_pid));
   assign prev_addr = ADDR_W'(32'(item_ff.outgoing_pid));
   assign pid_ok    = (item_ff.task_pid != '0) && (32'(item_ff.task_pid) < 32'(PID_SLOTS));
   assign prev_ok   = (item_ff.outgoing_pid != '0) &&
                      (32'(item_ff.outgoing_pid) < 32'(PID_SLOTS));

   assign hit         = pid_ok && mem_rd_data.valid;
   assign diff        = {1'b0, item_ff.now_ns} - {1'b0, mem_rd_data.stamp};
   assign time_ok     = !diff[63];
   assign above_floor = diff[62:0] >= 63'(min_lat_ff);

   assign csr_wr = psel && penable && pwrite && !paddr[3];

   rlet_stamp_mem #(
      .DEPTH  (PID_SLOTS),
      .ADDR_W (ADDR_W)
   ) u_stamp_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (pid_addr),
      .rd_data (mem_rd_data)
   );

   rlet_bucket #(
      .OVERFLOW_BUCKET (OVERFLOW_BUCKET)
   ) u_bucket (
      .lat_ns (lat_ff),
      .bucket (bucket)
   );

   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      item_in      = item_ff;
      rec_in       = rec_ff;
      lat_in       = lat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      min_lat_in   = csr_wr ? pwdata[rlet_pkg::MIN_LAT_W-1:0] : min_lat_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = pid_addr;
      mem_wr_data  = '0;
      mem_rd_en    = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_cnt_ff;
            if (clr_cnt_ff == ADDR_W'(PID_SLOTS - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_cnt_in = clr_cnt_ff + ADDR_W'(1);
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               item_in  = req_data;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            rec_in   = 1'b0;
            lat_in   = '0;
            state_in = ST_EMIT;
            unique case (item_ff.cmd)
               rlet_pkg::CMD_WAKEUP: begin
                  if (pid_ok && !item_ff.woken_active) begin
                     mem_wr_en   = 1'b1;
                     mem_wr_data = '{valid: 1'b1, stamp: item_ff.now_ns};
                  end
               end
               rlet_pkg::CMD_EXIT: begin
                  mem_wr_en = pid_ok;
               end
               rlet_pkg::CMD_SWITCH: begin
                  if (prev_ok && (item_ff.preempt || item_ff.prev_running)) begin
                     mem_wr_en   = 1'b1;
                     mem_wr_addr = prev_addr;
                     mem_wr_data = '{valid: 1'b1, stamp: item_ff.now_ns};
                  end
                  state_in = ST_READ;
               end
               default: begin
               end
            endcase
         end
         ST_READ: begin
            mem_rd_en = 1'b1;
            state_in  = ST_CHECK;
         end
         ST_CHECK: begin
            // pop the incoming task's stamp
            mem_wr_en = hit;
            rec_in    = hit && time_ok && item_ff.next_tracked && above_floor;
            lat_in    = diff[62:0];
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               if (rec_ff) begin
                  rsp_data_in.recorded       = 1'b1;
                  rsp_data_in.victim_cgroup  = item_ff.next_cgroup;
                  rsp_data_in.bucket         = bucket;
                  rsp_data_in.culprit_cgroup =
                     (item_ff.outgoing_pid != '0 && !item_ff.prev_kthread) ?
                     item_ff.prev_cgroup : '0;
                  rsp_data_in.latency_ns     = lat_ff;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         min_lat_ff   <= rlet_pkg::MIN_LAT_RESET;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         min_lat_ff   <= min_lat_in;
      end
      item_ff     <= item_in;
      rec_ff      <= rec_in;
      lat_ff      <= lat_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign pready    = 1'b1;
   assign prdata    = paddr[3] ? '0 : rlet_pkg::CSR_DATA_W'(min_lat_ff);

   `RLET_ASSERT_NOW(a_no_accept_in_clear, clock, reset, state_ff == ST_CLEAR, !req_ready)
   `RLET_ASSERT_NOW(a_no_write_on_read, clock, reset, state_ff == ST_READ, !mem_wr_en)
   `RLET_ASSERT_NOW(a_record_above_floor, clock, reset, rsp_valid && rsp_data.recorded, rsp_data.latency_ns >= 63'(min_lat_ff))
   `RLET_ASSERT_NOW(a_empty_result_zero, clock, reset, rsp_valid && !rsp_data.recorded, rsp_data == '0)
   `RLET_ASSERT_NEXT(a_read_then_check, clock, reset, state_ff == ST_READ, state_ff == ST_CHECK)

endmodule

// ----- design/rlet_stamp_mem.sv -----
// pid-indexed stamp memory, one write port and one registered read port
module rlet_stamp_mem #(
   parameter int DEPTH  = rlet_pkg::DEF_PID_SLOTS,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [ADDR_W-1:0]         wr_addr,
   input  rlet_pkg::stamp_entry_type wr_data,
   input  logic                      rd_en,
   input  logic [ADDR_W-1:0]         rd_addr,
   output rlet_pkg::stamp_entry_type rd_data
);

   rlet_pkg::stamp_entry_type mem [DEPTH];
   rlet_pkg::stamp_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/rlet_bucket.sv -----
// log2-microsecond bucket of a latency, clamped at the overflow bucket
module rlet_bucket #(
   parameter int OVERFLOW_BUCKET = rlet_pkg::DEF_OVERFLOW_BUCKET
) (
   input  logic [62:0] lat_ns,
   output logic [4:0]  bucket
);

   logic [rlet_pkg::THR_W-1:0] lat_wide;
   logic [5:0]                 level;

   assign lat_wide = rlet_pkg::THR_W'(lat_ns);

   // thresholds are constants, compares are independent
   always_comb begin
      level = '0;
      for (int b = 1; b <= OVERFLOW_BUCKET; b++) begin
         if (lat_wide >= rlet_pkg::bucket_threshold(b)) begin
            level = 6'(b);
         end
      end
   end

   assign bucket = level[4:0];

endmodule
